// File: design/lci_pkg.sv
package lci_pkg;

   // Default sample and fraction widths of the colour invariant datapath.
   localparam int SAMPLE_BITS_DEFAULT   = 8;
   localparam int FRACTION_BITS_DEFAULT = 16;

   // Width of each result port; quotients wider than this saturate.
   localparam int OUT_BITS = 16;

   // One divider lane per squared difference.
   localparam int NUM_LANES = 3;
   localparam int LANE_RG   = 0;
   localparam int LANE_RB   = 1;
   localparam int LANE_GB   = 2;

   // Control that travels alongside the data from the second front stage through every division step.
   typedef struct packed {
      logic valid;
      logic degenerate;
   } stage_ctl_type;

endpackage

// File: design/lci_front.sv
module lci_front #(
   parameter int SAMPLE_BITS = lci_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   input  logic [SAMPLE_BITS-1:0]                          red,
   input  logic [SAMPLE_BITS-1:0]                          green,
   input  logic [SAMPLE_BITS-1:0]                          blue,
   output lci_pkg::stage_ctl_type                          out_ctl,
   output logic [2*SAMPLE_BITS+1:0]                        out_den,
   output logic [lci_pkg::NUM_LANES-1:0][2*SAMPLE_BITS+1:0] out_num
);

   localparam int SQ_BITS  = 2 * SAMPLE_BITS;
   localparam int DEN_BITS = 2 * SAMPLE_BITS + 2;

   logic [lci_pkg::NUM_LANES-1:0][SAMPLE_BITS-1:0] lhs;
   logic [lci_pkg::NUM_LANES-1:0][SAMPLE_BITS-1:0] rhs;
   logic [lci_pkg::NUM_LANES-1:0][SAMPLE_BITS-1:0] adiff;

   logic [lci_pkg::NUM_LANES-1:0][SQ_BITS-1:0]     sq_in;
   logic [lci_pkg::NUM_LANES-1:0][SQ_BITS-1:0]     sq_ff;
   logic                                           sq_valid_ff;

   logic [DEN_BITS-1:0]                            den_in;
   logic [DEN_BITS-1:0]                            den_ff;
   logic [lci_pkg::NUM_LANES-1:0][DEN_BITS-1:0]    num_ff;
   lci_pkg::stage_ctl_type                         ctl_in;
   lci_pkg::stage_ctl_type                         ctl_ff;

   always_comb begin
      lhs[lci_pkg::LANE_RG] = red;
      rhs[lci_pkg::LANE_RG] = green;
      lhs[lci_pkg::LANE_RB] = red;
      rhs[lci_pkg::LANE_RB] = blue;
      lhs[lci_pkg::LANE_GB] = green;
      rhs[lci_pkg::LANE_GB] = blue;
      for (int i = 0; i < lci_pkg::NUM_LANES; i++) begin
         adiff[i] = (lhs[i] >= rhs[i]) ? (lhs[i] - rhs[i]) : (rhs[i] - lhs[i]);
         sq_in[i] = SQ_BITS'(adiff[i]) * SQ_BITS'(adiff[i]);
      end
   end

   // First stage: absolute differences squared.
   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
      if (reset) begin
         sq_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff <= in_valid;
      end
   end

   always_comb begin
      den_in = DEN_BITS'(sq_ff[lci_pkg::LANE_RG]) + DEN_BITS'(sq_ff[lci_pkg::LANE_RB])
             + DEN_BITS'(sq_ff[lci_pkg::LANE_GB]);
      ctl_in.valid      = sq_valid_ff;
      ctl_in.degenerate = (sq_ff == '0);
   end

   // Second stage: the common divisor and the zero-divisor flag.
   always_ff @(posedge clock) begin
      den_ff <= den_in;
      for (int i = 0; i < lci_pkg::NUM_LANES; i++) begin
         num_ff[i] <= DEN_BITS'(sq_ff[i]);
      end
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_den = den_ff;
   assign out_num = num_ff;

endmodule

// File: design/lci_div_step.sv
module lci_div_step #(
   parameter int DEN_BITS = 2 * lci_pkg::SAMPLE_BITS_DEFAULT + 2,
   parameter int QUO_BITS = lci_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  lci_pkg::stage_ctl_type                       in_ctl,
   input  logic [DEN_BITS-1:0]                          in_den,
   input  logic [lci_pkg::NUM_LANES-1:0][DEN_BITS-1:0]  in_rem,
   input  logic [lci_pkg::NUM_LANES-1:0][QUO_BITS-1:0]  in_quo,
   output lci_pkg::stage_ctl_type                       out_ctl,
   output logic [DEN_BITS-1:0]                          out_den,
   output logic [lci_pkg::NUM_LANES-1:0][DEN_BITS-1:0]  out_rem,
   output logic [lci_pkg::NUM_LANES-1:0][QUO_BITS-1:0]  out_quo
);

   // One restoring division bit for each lane. The remainder stays below any
   // nonzero divisor, so the doubled remainder needs one extra bit only.
   logic [lci_pkg::NUM_LANES-1:0][DEN_BITS:0]   shifted;
   logic [lci_pkg::NUM_LANES-1:0][DEN_BITS:0]   reduced;
   logic [lci_pkg::NUM_LANES-1:0]               take;
   logic [lci_pkg::NUM_LANES-1:0][DEN_BITS-1:0] rem_in;
   logic [lci_pkg::NUM_LANES-1:0][QUO_BITS-1:0] quo_in;

   logic [lci_pkg::NUM_LANES-1:0][DEN_BITS-1:0] rem_ff;
   logic [lci_pkg::NUM_LANES-1:0][QUO_BITS-1:0] quo_ff;
   logic [DEN_BITS-1:0]                         den_ff;
   lci_pkg::stage_ctl_type                      ctl_ff;

   always_comb begin
      for (int i = 0; i < lci_pkg::NUM_LANES; i++) begin
         shifted[i] = {in_rem[i], 1'b0};
         take[i]    = (shifted[i] >= {1'b0, in_den});
         reduced[i] = shifted[i] - {1'b0, in_den};
         rem_in[i]  = take[i] ? reduced[i][DEN_BITS-1:0] : shifted[i][DEN_BITS-1:0];
         quo_in[i]  = {in_quo[i][QUO_BITS-2:0], take[i]};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= in_den;
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= in_ctl;
      end
   end

   assign out_ctl = ctl_ff;
   assign out_den = den_ff;
   assign out_rem = rem_ff;
   assign out_quo = quo_ff;

endmodule

// File: design/l1l2l3_color_invariant.sv
// Colour invariant l1 l2 l3 of one RGB pixel per clock outside reset.
//
// Input: a pixel beat is taken at each rising edge where start is high and
// busy is low. Busy is high only while reset is applied, so outside reset a
// new pixel may be offered in every cycle, back to back, without gaps.
// Output: each pixel yields exactly one result beat, shown for a single
// cycle with rsp_strobe high. The three results are (R-G)^2, (R-B)^2 and
// (G-B)^2 divided by their sum, unsigned with FRACTION_BITS fraction bits,
// truncated, and saturated to the 16-bit port where FRACTION_BITS exceeds 16.
// When all three samples are equal the sum is zero: the results read zero
// and rsp_degenerate is set.
// Pipeline: two front stages (squaring, then summing), one stage per quotient
// bit of the three-lane restoring divider, and an output register, in that
// order. Throughput is one pixel per cycle outside reset. Reset empties every
// stage; pixels in flight are dropped and no strobe follows for them. The
// receiver cannot stall, so the pipeline never holds.
module l1l2l3_color_invariant #(
   parameter int SAMPLE_BITS   = lci_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = lci_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [SAMPLE_BITS-1:0]       req_red,
   input  logic [SAMPLE_BITS-1:0]       req_green,
   input  logic [SAMPLE_BITS-1:0]       req_blue,
   output logic                         rsp_strobe,
   output logic [lci_pkg::OUT_BITS-1:0] rsp_inv_one,
   output logic [lci_pkg::OUT_BITS-1:0] rsp_inv_two,
   output logic [lci_pkg::OUT_BITS-1:0] rsp_inv_three,
   output logic                         rsp_degenerate
);

   localparam int DEN_BITS  = 2 * SAMPLE_BITS + 2;
   localparam int WIDE_BITS = FRACTION_BITS + lci_pkg::OUT_BITS;

   // Stage k of the chain feeds division step k; the last entry holds the
   // finished quotients.
   lci_pkg::stage_ctl_type                          ctl_chain [FRACTION_BITS+1];
   logic [DEN_BITS-1:0]                             den_chain [FRACTION_BITS+1];
   logic [lci_pkg::NUM_LANES-1:0][DEN_BITS-1:0]     rem_chain [FRACTION_BITS+1];
   logic [lci_pkg::NUM_LANES-1:0][FRACTION_BITS-1:0] quo_chain [FRACTION_BITS+1];

   logic [lci_pkg::NUM_LANES-1:0][WIDE_BITS-1:0]        quo_wide;
   logic [lci_pkg::NUM_LANES-1:0][lci_pkg::OUT_BITS-1:0] res_in;
   logic [lci_pkg::NUM_LANES-1:0][lci_pkg::OUT_BITS-1:0] res_ff;
   logic                                                strobe_ff;
   logic                                                degenerate_ff;

   // Pixels are refused only while reset is held.
   assign busy = reset;

   lci_front #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .in_valid(start & ~busy),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .out_ctl (ctl_chain[0]),
      .out_den (den_chain[0]),
      .out_num (rem_chain[0])
   );

   // Each quotient lane starts empty; since every numerator is below a nonzero
   // divisor, the numerator itself is the first partial remainder.
   assign quo_chain[0] = '0;

   for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_step
      lci_div_step #(
         .DEN_BITS(DEN_BITS),
         .QUO_BITS(FRACTION_BITS)
      ) u_step (
         .clock  (clock),
         .reset  (reset),
         .in_ctl (ctl_chain[k]),
         .in_den (den_chain[k]),
         .in_rem (rem_chain[k]),
         .in_quo (quo_chain[k]),
         .out_ctl(ctl_chain[k+1]),
         .out_den(den_chain[k+1]),
         .out_rem(rem_chain[k+1]),
         .out_quo(quo_chain[k+1])
      );
   end

   // Output stage: a zero divisor forces zeros, and a quotient wider than
   // the port saturates to all ones. The final remainders and divisor are
   // not needed here.
   always_comb begin
      for (int i = 0; i < lci_pkg::NUM_LANES; i++) begin
         quo_wide[i] = WIDE_BITS'(quo_chain[FRACTION_BITS][i]);
         if (ctl_chain[FRACTION_BITS].degenerate) begin
            res_in[i] = '0;
         end else if (|quo_wide[i][WIDE_BITS-1:lci_pkg::OUT_BITS]) begin
            res_in[i] = '1;
         end else begin
            res_in[i] = quo_wide[i][lci_pkg::OUT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff        <= res_in;
      degenerate_ff <= ctl_chain[FRACTION_BITS].degenerate;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= ctl_chain[FRACTION_BITS].valid;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_inv_one    = res_ff[lci_pkg::LANE_RG];
   assign rsp_inv_two    = res_ff[lci_pkg::LANE_RB];
   assign rsp_inv_three  = res_ff[lci_pkg::LANE_GB];
   assign rsp_degenerate = degenerate_ff;

endmodule

// File: design/lci_checker.sv
module lci_checker #(
   parameter int SAMPLE_BITS   = lci_pkg::SAMPLE_BITS_DEFAULT,
   parameter int FRACTION_BITS = lci_pkg::FRACTION_BITS_DEFAULT
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [SAMPLE_BITS-1:0]       req_red,
   input logic [SAMPLE_BITS-1:0]       req_green,
   input logic [SAMPLE_BITS-1:0]       req_blue,
   input logic                         rsp_strobe,
   input logic [lci_pkg::OUT_BITS-1:0] rsp_inv_one,
   input logic [lci_pkg::OUT_BITS-1:0] rsp_inv_two,
   input logic [lci_pkg::OUT_BITS-1:0] rsp_inv_three,
   input logic                         rsp_degenerate
);

   localparam int LATENCY  = FRACTION_BITS + 3;
   localparam int SUM_BITS = lci_pkg::OUT_BITS + 10;

   logic                accepted;
   logic [SUM_BITS-1:0] res_sum;

   assign accepted = start & ~busy;
   assign res_sum  = SUM_BITS'(rsp_inv_one) + SUM_BITS'(rsp_inv_two)
                   + SUM_BITS'(rsp_inv_three);

   // Every accepted pixel comes out after the fixed pipeline depth.
   a_beat_delivered: assert property (@(posedge clock) disable iff (reset)
      accepted |-> ##LATENCY rsp_strobe)
      else $error("accepted pixel produced no result beat");

   // No result beat appears without a pixel taken the pipeline depth before.
   a_no_spurious_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accepted, LATENCY))
      else $error("result beat without a matching pixel");

   // The degenerate flag follows the samples that entered.
   a_degenerate_match: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_degenerate ==
         (($past(req_red, LATENCY) == $past(req_green, LATENCY))
          && ($past(req_green, LATENCY) == $past(req_blue, LATENCY)))))
      else $error("degenerate flag does not match the pixel");

   // A degenerate pixel reads zero; otherwise the truncated fractions never
   // add up to more than one.
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_degenerate ? (res_sum == '0)
                                      : (res_sum <= (SUM_BITS'(1) << FRACTION_BITS))))
      else $error("result fractions out of range");

endmodule

bind l1l2l3_color_invariant lci_checker #(
   .SAMPLE_BITS  (SAMPLE_BITS),
   .FRACTION_BITS(FRACTION_BITS)
) u_lci_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_red       (req_red),
   .req_green     (req_green),
   .req_blue      (req_blue),
   .rsp_strobe    (rsp_strobe),
   .rsp_inv_one   (rsp_inv_one),
   .rsp_inv_two   (rsp_inv_two),
   .rsp_inv_three (rsp_inv_three),
   .rsp_degenerate(rsp_degenerate)
);
